// ===== design/hoi_pkg.sv =====
// shared types, constants and microprogram for the harmonic oscillator integrator
`default_nettype none
package hoi_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int FRAC_BITS       = 28;
	localparam int STEP_WIDTH      = 32;
	localparam int METHOD_WIDTH    = 3;
	localparam int DT_WIDTH        = 29;
	localparam int OMEGA_WIDTH     = 31;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
	localparam int SHIFT_WIDTH     = PROD_WIDTH - FRAC_BITS;
	localparam int DIV6_SHIFT      = 34;
	localparam int PC_WIDTH        = 6;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [PC_WIDTH-1:0] pc_t;

	localparam word_t ONE_VAL    = word_t'(64'd1 << FRAC_BITS);
	localparam word_t HALF_VAL   = word_t'(64'd1 << (FRAC_BITS - 1));
	// ceil(2^34 / 6), exact for magnitudes below 2^33
	localparam word_t RECIP6_VAL = 32'd2863311531;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_METHOD    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_STEP = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STIFFNESS = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_POS = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_MOM = 3'd4;

	localparam logic [METHOD_WIDTH-1:0] METH_EULER    = 3'd0;
	localparam logic [METHOD_WIDTH-1:0] METH_RK2      = 3'd1;
	localparam logic [METHOD_WIDTH-1:0] METH_RK4      = 3'd2;
	localparam logic [METHOD_WIDTH-1:0] METH_SYMPLECT = 3'd3;
	localparam logic [METHOD_WIDTH-1:0] METH_LEAPFROG = 3'd4;

	localparam pc_t PC_ENERGY   = 6'd0;
	localparam pc_t PC_EULER    = 6'd3;
	localparam pc_t PC_SYMPLECT = 6'd6;
	localparam pc_t PC_LEAPFROG = 6'd9;
	localparam pc_t PC_RK2      = 6'd13;
	localparam pc_t PC_RK4      = 6'd23;

	typedef enum logic [2:0] {
		K_SMUL,
		K_SMULN,
		K_UMUL,
		K_UMULH,
		K_DIV6
	} kind_t;

	typedef enum logic [3:0] {
		S_Q, S_P, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
		S_DT, S_HDT, S_OMEGA, S_ONE, S_HALF, S_RECIP6, S_ZERO
	} src_t;

	typedef enum logic [2:0] {
		D_Q, D_P, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5
	} dst_t;

	// dst = c + kind(a, b)
	typedef struct packed {
		kind_t kind;
		src_t  a_sel;
		src_t  b_sel;
		src_t  c_sel;
		logic  b_raw;
		dst_t  dst;
		logic  emit;
		logic  last;
	} uop_t;

	typedef struct packed {
		logic  load;
		kind_t kind;
		logic  b_raw;
	} alu_ctrl_t;

	function automatic uop_t mk(kind_t k, src_t a, src_t b, src_t c, logic raw, dst_t d,
			logic emit, logic last);
		uop_t u;
		u.kind  = k;
		u.a_sel = a;
		u.b_sel = b;
		u.c_sel = c;
		u.b_raw = raw;
		u.dst   = d;
		u.emit  = emit;
		u.last  = last;
		return u;
	endfunction

	function automatic uop_t ucode(pc_t pc);
		uop_t u;
		case (pc)
			// energy
			6'd0:  u = mk(K_UMULH, S_P,     S_P,      S_ZERO, 1'b0, D_T0, 1'b0, 1'b0);
			6'd1:  u = mk(K_UMUL,  S_Q,     S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd2:  u = mk(K_UMULH, S_OMEGA, S_T1,     S_T0,   1'b1, D_T0, 1'b1, 1'b0);
			// euler
			6'd3:  u = mk(K_SMULN, S_OMEGA, S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd4:  u = mk(K_SMUL,  S_DT,    S_P,      S_Q,    1'b0, D_Q,  1'b0, 1'b0);
			6'd5:  u = mk(K_SMUL,  S_DT,    S_T1,     S_P,    1'b0, D_P,  1'b0, 1'b1);
			// symplectic euler
			6'd6:  u = mk(K_SMUL,  S_DT,    S_P,      S_Q,    1'b0, D_Q,  1'b0, 1'b0);
			6'd7:  u = mk(K_SMULN, S_OMEGA, S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd8:  u = mk(K_SMUL,  S_DT,    S_T1,     S_P,    1'b0, D_P,  1'b0, 1'b1);
			// leapfrog
			6'd9:  u = mk(K_SMUL,  S_HDT,   S_P,      S_Q,    1'b0, D_Q,  1'b0, 1'b0);
			6'd10: u = mk(K_SMULN, S_OMEGA, S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd11: u = mk(K_SMUL,  S_DT,    S_T1,     S_P,    1'b0, D_P,  1'b0, 1'b0);
			6'd12: u = mk(K_SMUL,  S_HDT,   S_P,      S_Q,    1'b0, D_Q,  1'b0, 1'b1);
			// rk2 midpoint
			6'd13: u = mk(K_SMUL,  S_DT,    S_P,      S_ZERO, 1'b0, D_T0, 1'b0, 1'b0);
			6'd14: u = mk(K_SMULN, S_OMEGA, S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd15: u = mk(K_SMUL,  S_DT,    S_T1,     S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd16: u = mk(K_SMUL,  S_T1,    S_HALF,   S_P,    1'b0, D_T1, 1'b0, 1'b0);
			6'd17: u = mk(K_SMUL,  S_DT,    S_T1,     S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd18: u = mk(K_SMUL,  S_T0,    S_HALF,   S_Q,    1'b0, D_T0, 1'b0, 1'b0);
			6'd19: u = mk(K_SMULN, S_OMEGA, S_T0,     S_ZERO, 1'b0, D_T0, 1'b0, 1'b0);
			6'd20: u = mk(K_SMUL,  S_DT,    S_T0,     S_ZERO, 1'b0, D_T0, 1'b0, 1'b0);
			6'd21: u = mk(K_SMUL,  S_ONE,   S_T1,     S_Q,    1'b0, D_Q,  1'b0, 1'b0);
			6'd22: u = mk(K_SMUL,  S_ONE,   S_T0,     S_P,    1'b0, D_P,  1'b0, 1'b1);
			// rk4: k1, k2
			6'd23: u = mk(K_SMUL,  S_DT,    S_P,      S_ZERO, 1'b0, D_T0, 1'b0, 1'b0);
			6'd24: u = mk(K_SMULN, S_OMEGA, S_Q,      S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd25: u = mk(K_SMUL,  S_DT,    S_T1,     S_ZERO, 1'b0, D_T1, 1'b0, 1'b0);
			6'd26: u = mk(K_SMUL,  S_T1,    S_HALF,   S_P,    1'b0, D_T2, 1'b0, 1'b0);
			6'd27: u = mk(K_SMUL,  S_DT,    S_T2,     S_ZERO, 1'b0, D_T2, 1'b0, 1'b0);
			6'd28: u = mk(K_SMUL,  S_T0,    S_HALF,   S_Q,    1'b0, D_T3, 1'b0, 1'b0);
			6'd29: u = mk(K_SMULN, S_OMEGA, S_T3,     S_ZERO, 1'b0, D_T3, 1'b0, 1'b0);
			6'd30: u = mk(K_SMUL,  S_DT,    S_T3,     S_ZERO, 1'b0, D_T3, 1'b0, 1'b0);
			// rk4: running sums with k2 twice
			6'd31: u = mk(K_SMUL,  S_ONE,   S_T2,     S_T0,   1'b0, D_T0, 1'b0, 1'b0);
			6'd32: u = mk(K_SMUL,  S_ONE,   S_T2,     S_T0,   1'b0, D_T0, 1'b0, 1'b0);
			6'd33: u = mk(K_SMUL,  S_ONE,   S_T3,     S_T1,   1'b0, D_T1, 1'b0, 1'b0);
			6'd34: u = mk(K_SMUL,  S_ONE,   S_T3,     S_T1,   1'b0, D_T1, 1'b0, 1'b0);
			// rk4: k3
			6'd35: u = mk(K_SMUL,  S_T3,    S_HALF,   S_P,    1'b0, D_T4, 1'b0, 1'b0);
			6'd36: u = mk(K_SMUL,  S_DT,    S_T4,     S_ZERO, 1'b0, D_T4, 1'b0, 1'b0);
			6'd37: u = mk(K_SMUL,  S_T2,    S_HALF,   S_Q,    1'b0, D_T5, 1'b0, 1'b0);
			6'd38: u = mk(K_SMULN, S_OMEGA, S_T5,     S_ZERO, 1'b0, D_T5, 1'b0, 1'b0);
			6'd39: u = mk(K_SMUL,  S_DT,    S_T5,     S_ZERO, 1'b0, D_T5, 1'b0, 1'b0);
			6'd40: u = mk(K_SMUL,  S_ONE,   S_T4,     S_T4,   1'b0, D_T2, 1'b0, 1'b0);
			6'd41: u = mk(K_SMUL,  S_ONE,   S_T2,     S_T0,   1'b0, D_T0, 1'b0, 1'b0);
			6'd42: u = mk(K_SMUL,  S_ONE,   S_T5,     S_T5,   1'b0, D_T3, 1'b0, 1'b0);
			6'd43: u = mk(K_SMUL,  S_ONE,   S_T3,     S_T1,   1'b0, D_T1, 1'b0, 1'b0);
			// rk4: k4
			6'd44: u = mk(K_SMUL,  S_ONE,   S_T5,     S_P,    1'b0, D_T2, 1'b0, 1'b0);
			6'd45: u = mk(K_SMUL,  S_DT,    S_T2,     S_ZERO, 1'b0, D_T2, 1'b0, 1'b0);
			6'd46: u = mk(K_SMUL,  S_ONE,   S_T2,     S_T0,   1'b0, D_T0, 1'b0, 1'b0);
			6'd47: u = mk(K_SMUL,  S_ONE,   S_T4,     S_Q,    1'b0, D_T3, 1'b0, 1'b0);
			6'd48: u = mk(K_SMULN, S_OMEGA, S_T3,     S_ZERO, 1'b0, D_T3, 1'b0, 1'b0);
			6'd49: u = mk(K_SMUL,  S_DT,    S_T3,     S_ZERO, 1'b0, D_T3, 1'b0, 1'b0);
			6'd50: u = mk(K_SMUL,  S_ONE,   S_T3,     S_T1,   1'b0, D_T1, 1'b0, 1'b0);
			// rk4: divide by six and update
			6'd51: u = mk(K_DIV6,  S_T0,    S_RECIP6, S_Q,    1'b1, D_Q,  1'b0, 1'b0);
			6'd52: u = mk(K_DIV6,  S_T1,    S_RECIP6, S_P,    1'b1, D_P,  1'b0, 1'b1);
			default: u = mk(K_SMUL, S_ZERO, S_ZERO,   S_ZERO, 1'b0, D_T5, 1'b0, 1'b1);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== design/hoi_if.sv =====
// tick and result channel interfaces of the harmonic oscillator integrator
`default_nettype none
interface hoi_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface hoi_result_if;
	logic valid;
	logic ready;
	logic [hoi_pkg::DATA_WIDTH-1:0] position_out;
	logic [hoi_pkg::DATA_WIDTH-1:0] momentum_out;
	logic [hoi_pkg::DATA_WIDTH-1:0] energy_out;
	logic [hoi_pkg::STEP_WIDTH-1:0] step_index;

	modport source (output valid, output position_out, output momentum_out,
		output energy_out, output step_index, input ready);
	modport sink (input valid, input position_out, input momentum_out,
		input energy_out, input step_index, output ready);
endinterface
`default_nettype wire

// ===== design/harmonic_oscillator_integrator_top.sv =====
// harmonic oscillator integrator top: microcoded sequencer around one shared multiplier
// each micro-op runs through ST_MUL (multiply), then ST_POST (saturate and accumulate)
// a tick is taken only in idle; it runs the energy micro-ops, waits for a free result
// register, then n step micro-ops, n = 3 euler/symplectic, 4 leapfrog, 10 rk2, 30 rk4
// reset: state and step count cleared, registers take their documented defaults
`default_nettype none
module harmonic_oscillator_integrator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [hoi_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [hoi_pkg::DATA_WIDTH-1:0]         cfg_data,
	hoi_tick_if.sink                               tick,
	hoi_result_if.source                           result
);
	localparam int DW = hoi_pkg::DATA_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_POST,
		ST_EMIT
	} state_t;

	logic [hoi_pkg::METHOD_WIDTH-1:0] method_q;
	logic [hoi_pkg::DT_WIDTH-1:0]     dt_q;
	logic [hoi_pkg::OMEGA_WIDTH-1:0]  omega_q;
	hoi_pkg::word_t                   start_pos_q;
	hoi_pkg::word_t                   start_mom_q;

	state_t                           state_q;
	hoi_pkg::pc_t                     pc_q;
	hoi_pkg::pc_t                     start_pc;
	hoi_pkg::word_t                   q_q, p_q, t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;
	logic [hoi_pkg::STEP_WIDTH-1:0]   step_q;
	hoi_pkg::word_t                   pos_out_q, mom_out_q, energy_out_q;
	logic [hoi_pkg::STEP_WIDTH-1:0]   step_out_q;
	logic                             out_valid_q;

	hoi_pkg::uop_t                    uop;
	hoi_pkg::word_t                   srcv [16];
	hoi_pkg::alu_ctrl_t               alu_ctrl;
	hoi_pkg::word_t                   alu_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q    <= hoi_pkg::METH_LEAPFROG;
			dt_q        <= 29'd13421773;
			omega_q     <= 31'd268435456;
			start_pos_q <= 32'd268435456;
			start_mom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hoi_pkg::REG_METHOD:    method_q    <= cfg_data[hoi_pkg::METHOD_WIDTH-1:0];
				hoi_pkg::REG_TIME_STEP: dt_q        <= cfg_data[hoi_pkg::DT_WIDTH-1:0];
				hoi_pkg::REG_STIFFNESS: omega_q     <= cfg_data[hoi_pkg::OMEGA_WIDTH-1:0];
				hoi_pkg::REG_START_POS: start_pos_q <= cfg_data;
				hoi_pkg::REG_START_MOM: start_mom_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign uop = hoi_pkg::ucode(pc_q);

	always_comb begin
		srcv = '{default: '0};
		srcv[hoi_pkg::S_Q]      = q_q;
		srcv[hoi_pkg::S_P]      = p_q;
		srcv[hoi_pkg::S_T0]     = t0_q;
		srcv[hoi_pkg::S_T1]     = t1_q;
		srcv[hoi_pkg::S_T2]     = t2_q;
		srcv[hoi_pkg::S_T3]     = t3_q;
		srcv[hoi_pkg::S_T4]     = t4_q;
		srcv[hoi_pkg::S_T5]     = t5_q;
		srcv[hoi_pkg::S_DT]     = DW'(dt_q);
		srcv[hoi_pkg::S_HDT]    = DW'(dt_q[hoi_pkg::DT_WIDTH-1:1]);
		srcv[hoi_pkg::S_OMEGA]  = DW'(omega_q);
		srcv[hoi_pkg::S_ONE]    = hoi_pkg::ONE_VAL;
		srcv[hoi_pkg::S_HALF]   = hoi_pkg::HALF_VAL;
		srcv[hoi_pkg::S_RECIP6] = hoi_pkg::RECIP6_VAL;
	end

	always_comb begin
		case (method_q)
			hoi_pkg::METH_EULER:    start_pc = hoi_pkg::PC_EULER;
			hoi_pkg::METH_RK2:      start_pc = hoi_pkg::PC_RK2;
			hoi_pkg::METH_RK4:      start_pc = hoi_pkg::PC_RK4;
			hoi_pkg::METH_SYMPLECT: start_pc = hoi_pkg::PC_SYMPLECT;
			default:                start_pc = hoi_pkg::PC_LEAPFROG;
		endcase
	end

	always_comb begin
		alu_ctrl.load  = (state_q == ST_MUL);
		alu_ctrl.kind  = uop.kind;
		alu_ctrl.b_raw = uop.b_raw;
	end

	hoi_alu u_alu (
		.clk  (clk),
		.ctrl (alu_ctrl),
		.a    (srcv[uop.a_sel]),
		.b    (srcv[uop.b_sel]),
		.c    (srcv[uop.c_sel]),
		.res  (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= hoi_pkg::PC_ENERGY;
			q_q          <= '0;
			p_q          <= '0;
			t0_q         <= '0;
			t1_q         <= '0;
			t2_q         <= '0;
			t3_q         <= '0;
			t4_q         <= '0;
			t5_q         <= '0;
			step_q       <= '0;
			pos_out_q    <= '0;
			mom_out_q    <= '0;
			energy_out_q <= '0;
			step_out_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (result.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick.valid) begin
						if (tick.restart) begin
							q_q    <= start_pos_q;
							p_q    <= start_mom_q;
							step_q <= '0;
						end
						pc_q    <= hoi_pkg::PC_ENERGY;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					case (uop.dst)
						hoi_pkg::D_Q:  q_q  <= alu_res;
						hoi_pkg::D_P:  p_q  <= alu_res;
						hoi_pkg::D_T0: t0_q <= alu_res;
						hoi_pkg::D_T1: t1_q <= alu_res;
						hoi_pkg::D_T2: t2_q <= alu_res;
						hoi_pkg::D_T3: t3_q <= alu_res;
						hoi_pkg::D_T4: t4_q <= alu_res;
						default:       t5_q <= alu_res;
					endcase
					if (uop.emit) begin
						state_q <= ST_EMIT;
					end else if (uop.last) begin
						state_q <= ST_IDLE;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || result.ready) begin
						pos_out_q    <= q_q;
						mom_out_q    <= p_q;
						energy_out_q <= t0_q;
						step_out_q   <= step_q;
						out_valid_q  <= 1'b1;
						step_q       <= step_q + 1'b1;
						pc_q         <= start_pc;
						state_q      <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tick.ready          = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.position_out = pos_out_q;
	assign result.momentum_out = mom_out_q;
	assign result.energy_out   = energy_out_q;
	assign result.step_index   = step_out_q;
endmodule
`default_nettype wire

// ===== design/hoi_alu.sv =====
// shared multiply, saturate and accumulate unit: res = c + kind(a, b) in the cycle after load
`default_nettype none
module hoi_alu (
	input  logic                clk,
	input  hoi_pkg::alu_ctrl_t  ctrl,
	input  hoi_pkg::word_t      a,
	input  hoi_pkg::word_t      b,
	input  hoi_pkg::word_t      c,
	output hoi_pkg::word_t      res
);
	localparam int DW = hoi_pkg::DATA_WIDTH;
	localparam int PW = hoi_pkg::PROD_WIDTH;
	localparam int SW = hoi_pkg::SHIFT_WIDTH;

	logic            a_neg;
	logic            b_neg;
	hoi_pkg::word_t  a_mag;
	hoi_pkg::word_t  b_mag;
	logic [PW-1:0]   prod_s1;
	logic            neg_s1;
	hoi_pkg::kind_t  kind_s1;

	logic [SW-1:0]   sh;
	logic [DW:0]     lim;
	logic [DW:0]     smag;
	logic [DW:0]     sval;
	logic [DW:0]     nval;
	logic [DW:0]     sv;
	logic [DW:0]     ssum;
	hoi_pkg::word_t  sres;
	hoi_pkg::word_t  umag;
	hoi_pkg::word_t  uval;
	logic [DW:0]     usum;
	hoi_pkg::word_t  ures;

	always_comb begin
		a_neg = a[DW-1];
		a_mag = a_neg ? (~a + 1'b1) : a;
		b_neg = b[DW-1] & ~ctrl.b_raw;
		b_mag = b_neg ? (~b + 1'b1) : b;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= {{DW{1'b0}}, a_mag} * {{DW{1'b0}}, b_mag};
			neg_s1  <= a_neg ^ b_neg;
			kind_s1 <= ctrl.kind;
		end
	end

	always_comb begin
		sh  = prod_s1[PW-1:hoi_pkg::FRAC_BITS];
		lim = neg_s1 ? {2'b01, {(DW-1){1'b0}}} : {2'b00, {(DW-1){1'b1}}};
		if (kind_s1 == hoi_pkg::K_DIV6) begin
			smag = (DW+1)'(prod_s1[PW-1:hoi_pkg::DIV6_SHIFT]);
		end else begin
			smag = (sh > SW'(lim)) ? lim : sh[DW:0];
		end
		sval = neg_s1 ? (~smag + 1'b1) : smag;
		nval = (sval == {2'b11, {(DW-1){1'b0}}}) ? {2'b00, {(DW-1){1'b1}}} : (~sval + 1'b1);
		sv   = (kind_s1 == hoi_pkg::K_SMULN) ? nval : sval;
		ssum = {c[DW-1], c} + sv;
		if (ssum[DW] != ssum[DW-1]) begin
			sres = ssum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			sres = ssum[DW-1:0];
		end

		umag = (sh > SW'({DW{1'b1}})) ? {DW{1'b1}} : sh[DW-1:0];
		uval = (kind_s1 == hoi_pkg::K_UMULH) ? (umag >> 1) : umag;
		usum = {1'b0, c} + {1'b0, uval};
		ures = usum[DW] ? {DW{1'b1}} : usum[DW-1:0];

		res = (kind_s1 == hoi_pkg::K_UMUL || kind_s1 == hoi_pkg::K_UMULH) ? ures : sres;
	end
endmodule
`default_nettype wire

// ===== design/hoi_checker.sv =====
// port-level assertions for the harmonic oscillator integrator and their bind
`default_nettype none
module hoi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               tick_valid,
	input logic                               tick_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic [hoi_pkg::DATA_WIDTH-1:0]     position_out,
	input logic [hoi_pkg::DATA_WIDTH-1:0]     momentum_out,
	input logic [hoi_pkg::DATA_WIDTH-1:0]     energy_out,
	input logic [hoi_pkg::STEP_WIDTH-1:0]     step_index
);
	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(position_out) && $stable(momentum_out)
			&& $stable(energy_out) && $stable(step_index))
		else $error("result payload changed while stalled");

	// a tick transaction holds tick ready low through ST_MUL and ST_POST of the first energy micro-op
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready ##1 !tick_ready)
		else $error("tick accepted again too early");

	// a new result is only produced while the step is still being advanced
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !tick_ready)
		else $error("result appeared while idle");
endmodule

bind harmonic_oscillator_integrator_top hoi_checker u_hoi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.position_out (result.position_out),
	.momentum_out (result.momentum_out),
	.energy_out   (result.energy_out),
	.step_index   (result.step_index)
);
`default_nettype wire
